### hdl/gtg_pkg.sv
// shared types, constants and angle table for the go-to-goal drive unit
`default_nettype none
package gtg_pkg;
    localparam int SQ_STEPS = 32;
    localparam int CW = 36;
    localparam int ZW = 25;
    localparam int ANG_HALF_PI = 1647099;
    localparam int ANG_PI = 3294199;
    localparam int ANG_TWO_PI = 6588397;

    localparam logic [2:0] REG_GOAL_X = 3'd0;
    localparam logic [2:0] REG_GOAL_Z = 3'd1;
    localparam logic [2:0] REG_GOAL_LOADED = 3'd2;
    localparam logic [2:0] REG_SPEED_GAIN = 3'd3;
    localparam logic [2:0] REG_WHEEL_BASE = 3'd4;
    localparam logic [2:0] REG_WHEEL_SCALE = 3'd5;
    localparam logic [2:0] REG_MAX_SPEED = 3'd6;
    localparam logic [2:0] REG_REACH_THR = 3'd7;

    typedef struct packed {
        logic                 valid;
        logic [63:0]          rem;
        logic [63:0]          root;
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic signed [ZW-1:0] cz;
        logic                 zero;
        logic                 big;
        logic signed [15:0]   head;
    } cell_t;

    function automatic logic signed [ZW-1:0] atan_q20(input int i);
        logic signed [ZW-1:0] a;
        unique case (i)
            0:  a = 25'sd823550;
            1:  a = 25'sd486170;
            2:  a = 25'sd256879;
            3:  a = 25'sd130396;
            4:  a = 25'sd65451;
            5:  a = 25'sd32757;
            6:  a = 25'sd16383;
            7:  a = 25'sd8192;
            8:  a = 25'sd4096;
            9:  a = 25'sd2048;
            10: a = 25'sd1024;
            11: a = 25'sd512;
            12: a = 25'sd256;
            13: a = 25'sd128;
            14: a = 25'sd64;
            15: a = 25'sd32;
            16: a = 25'sd16;
            17: a = 25'sd8;
            18: a = 25'sd4;
            19: a = 25'sd2;
            20: a = 25'sd1;
            default: a = '0;
        endcase
        return a;
    endfunction
endpackage
`default_nettype wire

### hdl/gtg_prep.sv
// front stages: offsets, squares and cordic quadrant pre-rotation
`default_nettype none
module gtg_prep (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                take,
    input  wire logic signed [31:0]  pos_x,
    input  wire logic signed [31:0]  pos_z,
    input  wire logic signed [15:0]  heading,
    input  wire logic signed [31:0]  goal_x,
    input  wire logic signed [31:0]  goal_z,
    output gtg_pkg::cell_t           dout
);
    logic               v1_reg, v2_reg, v3_reg;
    logic signed [31:0] px_reg, pz_reg;
    logic signed [15:0] h1_reg, h2_reg, h3_reg;
    logic signed [32:0] dx_reg, dz_reg;
    logic [31:0]        axs_reg, azs_reg;
    logic               big2_reg, big3_reg;
    logic [63:0]        sqx_reg, sqz_reg;
    logic signed [gtg_pkg::CW-1:0] x0_reg, y0_reg;
    logic signed [gtg_pkg::ZW-1:0] z0_reg;
    logic               zero_reg;
    gtg_pkg::cell_t     dout_reg;

    logic signed [32:0] dx, dz;
    logic [32:0]        ax, az;
    logic               big;
    logic signed [gtg_pkg::CW-1:0] ex, ez, x0_next, y0_next;
    logic signed [gtg_pkg::ZW-1:0] z0_next;
    gtg_pkg::cell_t     dout_next;

    always_comb
    begin
        dx = 33'(goal_x) - 33'(px_reg);
        dz = 33'(goal_z) - 33'(pz_reg);
        ax = dx[32] ? 33'(-dx) : 33'(dx);
        az = dz[32] ? 33'(-dz) : 33'(dz);
        big = ax[32] | ax[31] | az[32] | az[31];
    end

    always_comb
    begin
        ex = gtg_pkg::CW'(dx_reg);
        ez = gtg_pkg::CW'(dz_reg);
        x0_next = ex;
        y0_next = ez;
        z0_next = '0;
        if (ex < 0)
        begin
            if (ez >= 0)
            begin
                x0_next = ez;
                y0_next = -ex;
                z0_next = gtg_pkg::ZW'(gtg_pkg::ANG_HALF_PI);
            end
            else
            begin
                x0_next = -ez;
                y0_next = ex;
                z0_next = -gtg_pkg::ZW'(gtg_pkg::ANG_HALF_PI);
            end
        end
    end

    always_comb
    begin
        dout_next.valid = v3_reg;
        dout_next.rem = sqx_reg + sqz_reg;
        dout_next.root = '0;
        dout_next.cx = x0_reg;
        dout_next.cy = y0_reg;
        dout_next.cz = z0_reg;
        dout_next.zero = zero_reg;
        dout_next.big = big3_reg;
        dout_next.head = h3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            dout_reg <= '0;
        end
        else
        begin
            v1_reg <= take;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            dout_reg <= dout_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg <= pos_x;
        pz_reg <= pos_z;
        h1_reg <= heading;
        dx_reg <= dx;
        dz_reg <= dz;
        axs_reg <= big ? ax[32:1] : ax[31:0];
        azs_reg <= big ? az[32:1] : az[31:0];
        big2_reg <= big;
        h2_reg <= h1_reg;
        sqx_reg <= axs_reg * axs_reg;
        sqz_reg <= azs_reg * azs_reg;
        x0_reg <= x0_next;
        y0_reg <= y0_next;
        z0_reg <= z0_next;
        zero_reg <= (dx_reg == '0) && (dz_reg == '0);
        big3_reg <= big2_reg;
        h3_reg <= h2_reg;
    end

    assign dout = dout_reg;
endmodule
`default_nettype wire

### hdl/gtg_cell.sv
// one chain cell: one square-root digit and, while IDX < CORDIC_STEPS, one cordic vectoring step
`default_nettype none
module gtg_cell #(
    parameter int IDX = 0,
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire gtg_pkg::cell_t din,
    output gtg_pkg::cell_t      dout
);
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * IDX);
    localparam logic signed [gtg_pkg::ZW-1:0] ANG = gtg_pkg::atan_q20(IDX);

    gtg_pkg::cell_t dout_reg, dout_next;
    logic [63:0]    trial;
    logic signed [gtg_pkg::CW-1:0] xs, ys;

    always_comb
    begin
        dout_next = din;
        trial = din.root + BIT;
        xs = din.cx >>> IDX;
        ys = din.cy >>> IDX;
        if (din.rem >= trial)
        begin
            dout_next.rem = din.rem - trial;
            dout_next.root = (din.root >> 1) + BIT;
        end
        else
        begin
            dout_next.root = din.root >> 1;
        end
        if (IDX < CORDIC_STEPS)
        begin
            if (!din.cy[gtg_pkg::CW-1])
            begin
                dout_next.cx = din.cx + ys;
                dout_next.cy = din.cy - xs;
                dout_next.cz = din.cz + ANG;
            end
            else
            begin
                dout_next.cx = din.cx - ys;
                dout_next.cy = din.cy + xs;
                dout_next.cz = din.cz - ANG;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dout_reg <= '0;
        else
            dout_reg <= dout_next;
    end

    assign dout = dout_reg;
endmodule
`default_nettype wire

### hdl/gtg_post.sv
// back stages: heading error, turn and forward speed, wheel mix and clamp
`default_nettype none
module gtg_post (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire gtg_pkg::cell_t din,
    input  wire logic           goal_loaded,
    input  wire logic [15:0]    speed_gain,
    input  wire logic [15:0]    wheel_base,
    input  wire logic [15:0]    wheel_scale,
    input  wire logic [14:0]    max_wheel_speed,
    input  wire logic [30:0]    reach_threshold,
    output logic                done,
    output logic signed [15:0]  right_speed,
    output logic signed [15:0]  left_speed,
    output logic                goal_reached
);
    logic [5:0] v_reg;
    logic [4:0] rc_reg;
    logic signed [23:0] e_reg;
    logic [33:0]        d_reg;
    logic signed [58:0] w_reg;
    logic [49:0]        v2_reg, v3_reg;
    logic [37:0]        tlo_reg;
    logic signed [41:0] thi_reg;
    logic signed [48:0] ar_reg, al_reg;
    logic [42:0]        rlo_reg, llo_reg;
    logic signed [38:0] rhi_reg, lhi_reg;
    logic signed [15:0] right_reg, left_reg;
    logic               reached_reg;

    logic signed [25:0] e0, e1, e2;
    logic [33:0]        d;
    logic signed [46:0] ws;
    logic signed [63:0] tfull;
    logic signed [56:0] t, sr, sl;
    logic signed [65:0] rfull, lfull;
    logic signed [41:0] rs, ls;
    logic signed [41:0] lim;
    logic signed [15:0] rc, lc;

    always_comb
    begin
        e0 = (din.zero ? 26'sd0 : 26'(din.cz)) - (26'(din.head) <<< 7);
        e1 = (e0 > 26'sd3294199) ? e0 - 26'(gtg_pkg::ANG_TWO_PI) : e0;
        e2 = (e1 <= -26'sd3294199) ? e1 + 26'(gtg_pkg::ANG_TWO_PI) : e1;
        d = din.big ? {din.root[32:0], 1'b0} : 34'(din.root[32:0]);
    end

    always_comb
    begin
        ws = 47'(w_reg >>> 12);
        tfull = (64'(thi_reg) <<< 22) + 64'(tlo_reg);
        t = 57'(tfull >>> 9);
        sr = 57'(v3_reg) + t;
        sl = 57'(v3_reg) - t;
        rfull = (66'(rhi_reg) <<< 27) + 66'(rlo_reg);
        lfull = (66'(lhi_reg) <<< 27) + 66'(llo_reg);
        rs = 42'(rfull >>> 24);
        ls = 42'(lfull >>> 24);
        lim = 42'(max_wheel_speed);
        rc = (rs > lim) ? 16'(lim) : ((rs < -lim) ? 16'(-lim) : 16'(rs));
        lc = (ls > lim) ? 16'(lim) : ((ls < -lim) ? 16'(-lim) : 16'(ls));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
            rc_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[4:0], din.valid};
            rc_reg <= {rc_reg[3:0], (d < 34'(reach_threshold))};
        end
    end

    always_ff @(posedge clk)
    begin
        e_reg <= 24'(e2);
        d_reg <= d;
        w_reg <= $signed({1'b0, d_reg}) * e_reg;
        v2_reg <= 50'(speed_gain * d_reg);
        tlo_reg <= ws[21:0] * wheel_base;
        thi_reg <= $signed(ws[46:22]) * $signed({1'b0, wheel_base});
        v3_reg <= v2_reg;
        ar_reg <= 49'(sr >>> 8);
        al_reg <= 49'(sl >>> 8);
        rlo_reg <= ar_reg[26:0] * wheel_scale;
        llo_reg <= al_reg[26:0] * wheel_scale;
        rhi_reg <= $signed(ar_reg[48:27]) * $signed({1'b0, wheel_scale});
        lhi_reg <= $signed(al_reg[48:27]) * $signed({1'b0, wheel_scale});
        right_reg <= goal_loaded ? rc : 16'sd0;
        left_reg <= goal_loaded ? lc : 16'sd0;
        reached_reg <= goal_loaded & rc_reg[4];
    end

    assign done = v_reg[5];
    assign right_speed = right_reg;
    assign left_speed = left_reg;
    assign goal_reached = reached_reg;
endmodule
`default_nettype wire

### hdl/go_to_goal_diff_drive_unit.sv
// top level: register file, front stages, cell chain and back stages
// A pose word is taken on any cycle with start high; busy never rises, so one
// word may follow another every clock. Each word's wheel speeds and reached
// flag appear with a one-cycle done strobe once it has passed through four
// front stages, the 32 cells of the square-root / cordic chain and six mixing
// stages. The receiver cannot stall, so done must be taken when it shows.
// Configuration writes are taken every cycle; write only while no word is in
// flight.
`default_nettype none
module go_to_goal_diff_drive_unit #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [31:0] pos_x,
    input  wire logic signed [31:0] pos_z,
    input  wire logic signed [15:0] heading,
    output logic                    done,
    output logic signed [15:0]      right_speed,
    output logic signed [15:0]      left_speed,
    output logic                    goal_reached,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [31:0]        cfg_data
);
    logic signed [31:0] goal_x_reg, goal_z_reg;
    logic               goal_loaded_reg;
    logic [15:0]        speed_gain_reg, wheel_base_reg, wheel_scale_reg;
    logic [14:0]        max_speed_reg;
    logic [30:0]        reach_thr_reg;

    gtg_pkg::cell_t chain [0:gtg_pkg::SQ_STEPS];

    assign busy = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            goal_x_reg <= '0;
            goal_z_reg <= '0;
            goal_loaded_reg <= 1'b0;
            speed_gain_reg <= 16'd512;
            wheel_base_reg <= 16'd205;
            wheel_scale_reg <= 16'd10813;
            max_speed_reg <= 15'd5120;
            reach_thr_reg <= 31'd327680;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                gtg_pkg::REG_GOAL_X:      goal_x_reg <= cfg_data;
                gtg_pkg::REG_GOAL_Z:      goal_z_reg <= cfg_data;
                gtg_pkg::REG_GOAL_LOADED: goal_loaded_reg <= cfg_data[0];
                gtg_pkg::REG_SPEED_GAIN:  speed_gain_reg <= cfg_data[15:0];
                gtg_pkg::REG_WHEEL_BASE:  wheel_base_reg <= cfg_data[15:0];
                gtg_pkg::REG_WHEEL_SCALE: wheel_scale_reg <= cfg_data[15:0];
                gtg_pkg::REG_MAX_SPEED:   max_speed_reg <= cfg_data[14:0];
                gtg_pkg::REG_REACH_THR:   reach_thr_reg <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    gtg_prep u_prep (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (start & ~busy),
        .pos_x   (pos_x),
        .pos_z   (pos_z),
        .heading (heading),
        .goal_x  (goal_x_reg),
        .goal_z  (goal_z_reg),
        .dout    (chain[0])
    );

    for (genvar i = 0; i < gtg_pkg::SQ_STEPS; i++)
    begin : g_cell
        gtg_cell #(
            .IDX          (i),
            .CORDIC_STEPS (CORDIC_STEPS)
        ) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .din   (chain[i]),
            .dout  (chain[i+1])
        );
    end

    gtg_post u_post (
        .clk             (clk),
        .rst_n           (rst_n),
        .din             (chain[gtg_pkg::SQ_STEPS]),
        .goal_loaded     (goal_loaded_reg),
        .speed_gain      (speed_gain_reg),
        .wheel_base      (wheel_base_reg),
        .wheel_scale     (wheel_scale_reg),
        .max_wheel_speed (max_speed_reg),
        .reach_threshold (reach_thr_reg),
        .done            (done),
        .right_speed     (right_speed),
        .left_speed      (left_speed),
        .goal_reached    (goal_reached)
    );
endmodule
`default_nettype wire

### hdl/gtg_checker.sv
// port-level checks for the go-to-goal drive unit and their bind
`default_nettype none
module gtg_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        done,
    input wire logic [15:0] right_speed,
    input wire logic [15:0] left_speed,
    input wire logic        cfg_valid,
    input wire logic        cfg_ready
);
    localparam int LAT = 42;

    a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start & ~busy, LAT))
        else $error("done without a word taken earlier");

    a_right_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> right_speed != 16'h8000)
        else $error("right speed out of clamp range");

    a_left_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> left_speed != 16'h8000)
        else $error("left speed out of clamp range");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("config word stalled");
endmodule

bind go_to_goal_diff_drive_unit gtg_checker u_gtg_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .right_speed (right_speed),
    .left_speed  (left_speed),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready)
);
`default_nettype wire

### verif/go_to_goal_diff_drive_unit_checker.sv
// checker for the go-to-goal drive unit: tracks registers, predicts wheel speeds, compares
`default_nettype none
module go_to_goal_diff_drive_unit_checker (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic               busy,
    input  wire logic signed [31:0] pos_x,
    input  wire logic signed [31:0] pos_z,
    input  wire logic signed [15:0] heading,
    input  wire logic               done,
    input  wire logic signed [15:0] right_speed,
    input  wire logic signed [15:0] left_speed,
    input  wire logic               goal_reached,
    input  wire logic               cfg_valid,
    input  wire logic               cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [31:0]        cfg_data,
    output int                      errors,
    output int                      pending
);
    typedef struct {
        logic signed [15:0] right;
        logic signed [15:0] left;
        logic               reached;
    } drive_cmd_t;

    localparam longint ARC_TAB [0:20] = '{
        823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
        4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1
    };
    localparam int STEPS = 16;

    logic signed [31:0] goal_x_q, goal_z_q;
    logic               loaded_q;
    logic [15:0]        gain_q, base_q, scale_q;
    logic [14:0]        max_q;
    logic [30:0]        thr_q;

    drive_cmd_t expected_cmds[$];

    assign pending = expected_cmds.size();

    initial errors = 0;

    function automatic longint unsigned int_root(longint unsigned n);
        longint unsigned res, bit_v;
        res = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > n)
            bit_v >>= 2;
        while (bit_v != 0)
        begin
            if (n >= res + bit_v)
            begin
                n = n - (res + bit_v);
                res = (res >> 1) + bit_v;
            end
            else
                res = res >> 1;
            bit_v >>= 2;
        end
        return res;
    endfunction

    function automatic longint bearing_q20(longint y, longint x);
        longint z, nx, ny, xs, ys;
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        if (x < 0)
        begin
            if (y >= 0)
            begin
                nx = y; ny = -x; z = gtg_pkg::ANG_HALF_PI;
            end
            else
            begin
                nx = -y; ny = x; z = -gtg_pkg::ANG_HALF_PI;
            end
            x = nx;
            y = ny;
        end
        for (int i = 0; i < STEPS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x = x + ys; y = y - xs; z = z + (i <= 20 ? ARC_TAB[i] : 0);
            end
            else
            begin
                x = x - ys; y = y + xs; z = z - (i <= 20 ? ARC_TAB[i] : 0);
            end
        end
        return z;
    endfunction

    function automatic drive_cmd_t predict_wheels(logic signed [31:0] px,
                                                  logic signed [31:0] pz,
                                                  logic signed [15:0] hd);
        drive_cmd_t c;
        longint dx, dz, head, err, w, v, t, r, l, lim;
        longint unsigned ax, az, d;
        c.right = 0;
        c.left = 0;
        c.reached = 0;
        if (!loaded_q)
            return c;
        dx = longint'(goal_x_q) - longint'(px);
        dz = longint'(goal_z_q) - longint'(pz);
        head = longint'(hd) * 128;
        ax = dx < 0 ? -dx : dx;
        az = dz < 0 ? -dz : dz;
        if (ax >= (64'd1 << 31) || az >= (64'd1 << 31))
        begin
            ax >>= 1;
            az >>= 1;
            d = int_root(ax * ax + az * az) << 1;
        end
        else
            d = int_root(ax * ax + az * az);
        err = bearing_q20(dz, dx) - head;
        if (err > gtg_pkg::ANG_PI)
            err = err - gtg_pkg::ANG_TWO_PI;
        if (err <= -gtg_pkg::ANG_PI)
            err = err + gtg_pkg::ANG_TWO_PI;
        w = longint'(d) * err;
        v = longint'(gain_q) * longint'(d);
        t = ((w >>> 12) * longint'(base_q)) >>> 9;
        r = (((v + t) >>> 8) * longint'(scale_q)) >>> 24;
        l = (((v - t) >>> 8) * longint'(scale_q)) >>> 24;
        lim = longint'(max_q);
        if (r > lim) r = lim;
        if (r < -lim) r = -lim;
        if (l > lim) l = lim;
        if (l < -lim) l = -lim;
        c.right = r[15:0];
        c.left = l[15:0];
        c.reached = d < longint'(thr_q);
        return c;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("error at %0t: %s got %0d expected %0d", $time, what, got, want);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        drive_cmd_t want;
        if (!rst_n)
        begin
            goal_x_q <= 0;
            goal_z_q <= 0;
            loaded_q <= 0;
            gain_q <= 16'd512;
            base_q <= 16'd205;
            scale_q <= 16'd10813;
            max_q <= 15'd5120;
            thr_q <= 31'd327680;
        end
        else
        begin
            if (done)
            begin
                if (expected_cmds.size() == 0)
                    report_mismatch("unexpected result word, right", right_speed, 0);
                else
                begin
                    want = expected_cmds.pop_front();
                    if (right_speed !== want.right)
                        report_mismatch("right_speed", right_speed, want.right);
                    if (left_speed !== want.left)
                        report_mismatch("left_speed", left_speed, want.left);
                    if (goal_reached !== want.reached)
                        report_mismatch("goal_reached", goal_reached, want.reached);
                end
            end
            if (start && !busy)
                expected_cmds.push_back(predict_wheels(pos_x, pos_z, heading));
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    gtg_pkg::REG_GOAL_X:      goal_x_q <= cfg_data;
                    gtg_pkg::REG_GOAL_Z:      goal_z_q <= cfg_data;
                    gtg_pkg::REG_GOAL_LOADED: loaded_q <= cfg_data[0];
                    gtg_pkg::REG_SPEED_GAIN:  gain_q <= cfg_data[15:0];
                    gtg_pkg::REG_WHEEL_BASE:  base_q <= cfg_data[15:0];
                    gtg_pkg::REG_WHEEL_SCALE: scale_q <= cfg_data[15:0];
                    gtg_pkg::REG_MAX_SPEED:   max_q <= cfg_data[14:0];
                    gtg_pkg::REG_REACH_THR:   thr_q <= cfg_data[30:0];
                    default: ;
                endcase
            end
        end
    end
endmodule
`default_nettype wire

### verif/tb_go_to_goal_diff_drive_unit.sv
// testbench top for the go-to-goal drive unit: stimulus, watchdog and verdict
`default_nettype none
module tb_go_to_goal_diff_drive_unit;
    localparam int IDLE_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 60;

    logic               clk = 0;
    logic               rst_n = 0;
    logic               start = 0;
    logic               busy;
    logic signed [31:0] pos_x = 0;
    logic signed [31:0] pos_z = 0;
    logic signed [15:0] heading = 0;
    logic               done;
    logic signed [15:0] right_speed, left_speed;
    logic               goal_reached;
    logic               cfg_valid = 0;
    logic               cfg_ready;
    logic [2:0]         cfg_index = 0;
    logic [31:0]        cfg_data = 0;
    int                 errors, pending;
    int                 idle_cycles = 0;
    logic signed [31:0] cur_gx = 0, cur_gz = 0;

    always #5 clk = ~clk;

    go_to_goal_diff_drive_unit dut (.*);

    go_to_goal_diff_drive_unit_checker u_checker (.*);

    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("go_to_goal_diff_drive_unit: mismatch");
            $finish;
        end
    end

    task automatic send_pose(logic signed [31:0] x, logic signed [31:0] z,
                             logic signed [15:0] h);
        int gap;
        @(negedge clk);
        pos_x <= x;
        pos_z <= z;
        heading <= h;
        start <= 1;
        do @(posedge clk); while (busy);
        gap = $urandom_range(0, 7);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        repeat (gap)
        begin
            @(negedge clk);
            start <= 0;
        end
    endtask

    task automatic drain();
        @(negedge clk);
        start <= 0;
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(negedge clk);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 0;
    endtask

    task automatic load_setup(logic [31:0] gx, logic [31:0] gz, logic ld,
                              logic [15:0] gain, logic [15:0] base,
                              logic [15:0] scale, logic [14:0] maxs,
                              logic [30:0] thr);
        drain();
        write_reg(gtg_pkg::REG_GOAL_X, gx);
        write_reg(gtg_pkg::REG_GOAL_Z, gz);
        write_reg(gtg_pkg::REG_GOAL_LOADED, {31'd0, ld});
        write_reg(gtg_pkg::REG_SPEED_GAIN, {16'd0, gain});
        write_reg(gtg_pkg::REG_WHEEL_BASE, {16'd0, base});
        write_reg(gtg_pkg::REG_WHEEL_SCALE, {16'd0, scale});
        write_reg(gtg_pkg::REG_MAX_SPEED, {17'd0, maxs});
        write_reg(gtg_pkg::REG_REACH_THR, {1'b0, thr});
        cur_gx = gx;
        cur_gz = gz;
    endtask

    function automatic logic signed [31:0] near_goal(logic signed [31:0] g, int mode);
        logic signed [31:0] off;
        case (mode)
            0: off = $urandom;
            1: off = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
            2: off = $signed($urandom_range(0, 1 << 27)) - (1 << 26);
            default: off = $signed($urandom_range(0, 64)) - 32;
        endcase
        return g - off;
    endfunction

    task automatic random_poses(int count);
        int mode;
        logic signed [15:0] h;
        for (int n = 0; n < count; n++)
        begin
            mode = $urandom_range(0, 3);
            if ($urandom_range(0, 7) == 0)
                h = 16'($urandom);
            else
                h = 16'($signed($urandom_range(0, 51472)) - 25736);
            send_pose(near_goal(cur_gx, mode), near_goal(cur_gz, mode), h);
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;

        // defaults, no goal loaded
        send_pose(32'sd1000, -32'sd5000, 16'sd100);
        send_pose(32'h7fffffff, 32'h80000000, -16'sd25736);
        random_poses(20);

        load_setup(32'd0, 32'd0, 1'b1, 16'd512, 16'd205, 16'd10813, 15'd5120,
                   31'd327680);
        send_pose(32'sd0, 32'sd0, 16'sd0);
        send_pose(32'sd65536, 32'sd0, 16'sd25736);
        send_pose(-32'sd65536, 32'sd0, -16'sd25736);
        send_pose(32'sd0, 32'sd65536, 16'sh7fff);
        send_pose(32'sd0, -32'sd65536, 16'sh8000);
        send_pose(-32'sd65536, -32'sd65536, 16'sd0);
        send_pose(32'sd65536, -32'sd65536, 16'sd12868);
        send_pose(32'sd1000, 32'sd1000, -16'sd12868);
        send_pose(32'h7fffffff, 32'h7fffffff, 16'sd1);

        load_setup(32'h7fffffff, 32'h80000000, 1'b1, 16'hffff, 16'hffff,
                   16'hffff, 15'h7fff, 31'h7fffffff);
        send_pose(32'h80000000, 32'h7fffffff, 16'sd25736);
        send_pose(32'h80000000, 32'h80000000, -16'sd25736);
        send_pose(32'h7fffffff, 32'h80000000, 16'sd0);
        send_pose(32'h7fffffff, 32'h7fffffff, 16'sh8000);
        send_pose(32'sd0, 32'sd0, 16'sh7fff);
        random_poses(180);

        load_setup(32'h80000000, 32'h7fffffff, 1'b1, 16'd0, 16'd0, 16'd0, 15'd0, 31'd0);
        send_pose(32'h7fffffff, 32'h80000000, 16'sd0);
        random_poses(150);

        load_setup($urandom, $urandom, 1'b1, 16'd512, 16'd205, 16'd10813, 15'd5120,
                   31'd327680);
        random_poses(200);

        for (int p = 0; p < 6; p++)
        begin
            load_setup($urandom, $urandom, p != 3, 16'($urandom), 16'($urandom),
                       16'($urandom), 15'($urandom), 31'($urandom_range(0, 1 << 24)));
            random_poses(130);
        end

        load_setup(32'sd65536, -32'sd65536, 1'b1, 16'd256, 16'hffff, 16'hffff,
                   15'h7fff, 31'h7fffffff);
        random_poses(200);

        drain();
        if (errors == 0)
            $display("go_to_goal_diff_drive_unit: match");
        else
            $display("go_to_goal_diff_drive_unit: mismatch");
        $finish;
    end
endmodule
`default_nettype wire

### sim.f
hdl/gtg_pkg.sv
hdl/gtg_prep.sv
hdl/gtg_cell.sv
hdl/gtg_post.sv
hdl/go_to_goal_diff_drive_unit.sv
hdl/gtg_checker.sv
verif/go_to_goal_diff_drive_unit_checker.sv
verif/tb_go_to_goal_diff_drive_unit.sv
